// ===== rtl/median_filter_3x3_defines.svh =====
// Assertion macros used by the checker file of the median filter.
// Each macro expects signals named clk and rst in the scope of its use.
`ifndef MEDIAN_FILTER_3X3_DEFINES_SVH
`define MEDIAN_FILTER_3X3_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define MF3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define MF3_ASSERT_AFTER_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ===== rtl/mf3_pkg.sv =====
`default_nettype none

package mf3_pkg;

  // Field and register widths
  localparam int DIM_W     = 11;
  localparam int PEND_W    = DIM_W + 1;
  localparam int CALC_W    = DIM_W + 2;
  localparam int PIX_W     = 8;
  localparam int WIN_N     = 9;
  localparam int CFG_IDX_W = 2;

  // Default frame size limits
  localparam int MF_MAX_WIDTH  = 1024;
  localparam int MF_MAX_HEIGHT = 1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Register reset values and lower bound
  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
  localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(3);

  // Input action codes
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_N-1:0] win_t;

  typedef struct packed {
    logic action;
    pix_t pixel;
  } in_t;

  typedef struct packed {
    pix_t filtered;
    logic last_of_frame;
  } out_t;

  // Load strobes for the median pipeline
  typedef struct packed {
    logic ld_rows;
    logic ld_pick;
  } med_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/median_filter_3x3.sv =====
`default_nettype none

// Streaming 3x3 median filter for 8-bit grayscale frames in raster order.
// The block takes one beat per clock while the output does not stall,
// pixel or drain alike; that rate is set by the two line stores, each a
// one-read, one-write memory that sees one read-modify-write per pixel,
// with the write of one pixel forwarded to the read of the next beat when
// they hit the same column. The median runs through a row sort stage and
// a column pick stage, with the final median of three combinational.
// Results trail the pixels by one line plus one pixel; pixels on the outer
// rows and columns pass unchanged. After the last pixel of a frame, send
// image_width + 1 drain beats to flush the final results; the last one is
// flagged last_of_frame. A register write restarts the frame and drops
// any pending results. Line stores are not cleared after reset, since no
// result reads a column before the current frame has written it.
module median_filter_3x3 #(
  parameter int MAX_WIDTH  = mf3_pkg::MF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mf3_pkg::MF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mf3_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mf3_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mf3_pkg::DIM_W-1:0]       cfg_data
);
  import mf3_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  typedef struct packed {
    logic emit;
    logic border;
    logic last;
    pix_t direct;
  } tag_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
    logic [DIM_W-1:0] res;
    res = v;
    if (v < DIM_MIN) res = DIM_MIN;
    else if (int'(v) > hi) res = DIM_W'(hi);
    return res;
  endfunction

  // Configuration and frame position
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [PEND_W-1:0] pend;

  // Line stores and their read registers
  pix_t mem_up  [MAX_WIDTH];
  pix_t mem_mid [MAX_WIDTH];
  pix_t rd_up;
  pix_t rd_mid;

  // 3x3 window, index 3*row + column, column 2 newest
  win_t win;

  // Pipeline stages
  logic             s1_v;
  logic             s1_drain;
  logic             s1_emit;
  logic             s1_border;
  logic             s1_top;
  logic             s1_last;
  pix_t             s1_px;
  logic [COL_W-1:0] s1_addr;
  logic             s2_v;
  logic             s3_v;
  logic             s4_v;
  tag_t             s2_tag;
  tag_t             s3_tag;
  tag_t             s4_tag;

  // Handshake and decode
  logic              acc;
  logic              is_drain;
  logic [CALC_W-1:0] c_x;
  logic [CALC_W-1:0] r_x;
  logic [CALC_W-1:0] w_x;
  logic [CALC_W-1:0] h_x;
  logic [CALC_W-1:0] p_x;
  logic              px_emit;
  logic              px_border;
  logic              col_end;
  logic              row_end;
  logic              dr_top;
  logic              dr_emit;
  logic [CALC_W-1:0] dr_addr_x;
  logic [COL_W-1:0]  rd_addr;
  logic              mem_we;
  logic              fwd;
  logic              out_free;
  logic              rdy1;
  logic              rdy2;
  logic              rdy3;
  logic              rdy4;
  logic              mv12;
  logic              mv23;
  logic              mv34;
  logic              leave4;
  logic              out_load;
  med_ctl_t          med_ctl;
  pix_t              med;

  assign cfg_ready = 1'b1;

  // Stage flow: each stage moves when the next one is free or moving
  assign out_free = !out_valid || out_ready;
  assign rdy4     = !s4_v || !s4_tag.emit || out_free;
  assign rdy3     = !s3_v || rdy4;
  assign rdy2     = !s2_v || rdy3;
  assign rdy1     = !s1_v || rdy2;
  assign in_ready = rdy1;
  assign acc      = in_valid && in_ready;
  assign mv12     = s1_v && rdy2;
  assign mv23     = s2_v && rdy3;
  assign mv34     = s3_v && rdy4;
  assign leave4   = s4_v && rdy4;
  assign out_load = s4_v && s4_tag.emit && out_free;

  // Beat decode
  assign is_drain  = (in_data.action == ACT_DRAIN);
  assign c_x       = CALC_W'(col);
  assign r_x       = CALC_W'(row);
  assign w_x       = CALC_W'(image_width);
  assign h_x       = CALC_W'(image_height);
  assign p_x       = CALC_W'(pend);
  assign px_emit   = (r_x >= CALC_W'(2)) || (r_x == CALC_W'(1) && c_x >= CALC_W'(1));
  assign px_border = !(r_x >= CALC_W'(2) && c_x >= CALC_W'(2));
  assign col_end   = (c_x + CALC_W'(1)) >= w_x;
  assign row_end   = (r_x + CALC_W'(1)) >= h_x;
  assign dr_top    = (p_x == w_x + CALC_W'(1));
  assign dr_emit   = (p_x != CALC_W'(0)) && (p_x <= w_x + CALC_W'(1));
  assign dr_addr_x = dr_top ? (w_x - CALC_W'(1)) : (w_x - p_x);
  assign rd_addr   = is_drain ? COL_W'(dr_addr_x) : col;

  // Configuration and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
      pend         <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT) begin
        col  <= '0;
        row  <= '0;
        pend <= '0;
      end
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= clamp_dim(cfg_data, MAX_WIDTH);
      end else if (cfg_index == REG_IMAGE_HEIGHT) begin
        image_height <= clamp_dim(cfg_data, MAX_HEIGHT);
      end
    end else if (acc) begin
      if (is_drain) begin
        if (dr_emit) pend <= pend - PEND_W'(1);
      end else begin
        pend <= '0;
        if (col_end) begin
          col <= '0;
          if (row_end) begin
            row  <= '0;
            pend <= PEND_W'(w_x + CALC_W'(1));
          end else begin
            row <= ROW_W'(r_x + CALC_W'(1));
          end
        end else begin
          col <= COL_W'(c_x + CALC_W'(1));
        end
      end
    end
  end

  // Line stores: read on accept, write back as the pixel leaves stage 1
  assign mem_we = mv12 && !s1_drain;
  assign fwd    = mem_we && (s1_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_up[s1_addr]  <= rd_mid;
      mem_mid[s1_addr] <= s1_px;
    end
    if (acc) begin
      rd_up  <= fwd ? rd_mid : mem_up[rd_addr];
      rd_mid <= fwd ? s1_px : mem_mid[rd_addr];
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_drain  <= is_drain;
      s1_emit   <= is_drain ? dr_emit : px_emit;
      s1_border <= is_drain || px_border;
      s1_top    <= dr_top;
      s1_last   <= is_drain && (p_x == CALC_W'(1));
      s1_px     <= in_data.pixel;
      s1_addr   <= rd_addr;
    end
  end

  // Window shift on every pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (mem_we) begin
      for (int i = 0; i < 3; i++) begin
        win[3*i]   <= win[3*i+1];
        win[3*i+1] <= win[3*i+2];
      end
      win[2] <= rd_up;
      win[5] <= rd_mid;
      win[8] <= s1_px;
    end
  end

  // Tags down the median pipeline
  always_ff @(posedge clk) begin
    if (mv12) begin
      s2_tag.emit   <= s1_emit;
      s2_tag.border <= s1_border;
      s2_tag.last   <= s1_last;
      s2_tag.direct <= s1_drain ? (s1_top ? rd_up : rd_mid) : win[5];
    end
    if (mv23) s3_tag <= s2_tag;
    if (mv34) s4_tag <= s3_tag;
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= acc  ? 1'b1 : (mv12 ? 1'b0 : s1_v);
      s2_v <= mv12 ? 1'b1 : (mv23 ? 1'b0 : s2_v);
      s3_v <= mv23 ? 1'b1 : (mv34 ? 1'b0 : s3_v);
      s4_v <= mv34 ? 1'b1 : (leave4 ? 1'b0 : s4_v);
    end
  end

  assign med_ctl.ld_rows = mv23;
  assign med_ctl.ld_pick = mv34;

  mf3_median u_median (
    .clk (clk),
    .win (win),
    .ctl (med_ctl),
    .med (med)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.filtered      <= s4_tag.border ? s4_tag.direct : med;
      out_data.last_of_frame <= s4_tag.last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mf3_median.sv =====
`default_nettype none

// Median of nine: sort each row of three, then take the max of the lows,
// the median of the mids and the min of the highs, then the median of those.
module mf3_median (
  input  logic              clk,
  input  mf3_pkg::win_t     win,
  input  mf3_pkg::med_ctl_t ctl,
  output mf3_pkg::pix_t     med
);
  import mf3_pkg::*;

  pix_t row_lo [3];
  pix_t row_md [3];
  pix_t row_hi [3];
  pix_t pick_lo;
  pix_t pick_md;
  pix_t pick_hi;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Row sort stage
  always_ff @(posedge clk) begin
    if (ctl.ld_rows) begin
      for (int i = 0; i < 3; i++) begin
        row_lo[i] <= min2(min2(win[3*i], win[3*i+1]), win[3*i+2]);
        row_md[i] <= med3(win[3*i], win[3*i+1], win[3*i+2]);
        row_hi[i] <= max2(max2(win[3*i], win[3*i+1]), win[3*i+2]);
      end
    end
  end

  // Column pick stage
  always_ff @(posedge clk) begin
    if (ctl.ld_pick) begin
      pick_lo <= max2(max2(row_lo[0], row_lo[1]), row_lo[2]);
      pick_md <= med3(row_md[0], row_md[1], row_md[2]);
      pick_hi <= min2(min2(row_hi[0], row_hi[1]), row_hi[2]);
    end
  end

  assign med = med3(pick_lo, pick_md, pick_hi);

endmodule

`default_nettype wire

// ===== rtl/mf3_checker.sv =====
`default_nettype none
`include "median_filter_3x3_defines.svh"

module mf3_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input mf3_pkg::out_t out_data
);
  import mf3_pkg::*;

  // Output register is empty after reset
  `MF3_ASSERT_AFTER_RESET(a_rst_empty, !out_valid, "result valid right after reset")

  // A stalled result beat holds
  `MF3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // With the output register empty nothing can back up into the input
  `MF3_ASSERT_NOW(a_ready_free, !out_valid, in_ready, "input stalled with output empty")

  // Two frame ends never leave on neighboring beats
  `MF3_ASSERT_NEXT(a_last_once, out_valid && out_ready && out_data.last_of_frame, !(out_valid && out_data.last_of_frame), "frame end repeated")

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
